// ===== hdl/subnet_acl_match_defines.svh =====
// ----------------------------------------------------------------------------
// subnet_acl_match_defines.svh
// Assertion macros used by the subnet ACL checker file.
// ----------------------------------------------------------------------------
`ifndef SUBNET_ACL_MATCH_DEFINES_SVH
`define SUBNET_ACL_MATCH_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define SAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property must never hold at any clock edge out of reset.
`define SAM_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ===== hdl/sam_pkg.sv =====
// ----------------------------------------------------------------------------
// sam_pkg
// Types, constants and mask helper for the subnet ACL match block.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int CntW          = $clog2(TABLE_ENTRIES + 1);
  localparam int IdxW          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int AddrW  = 128;
  localparam int HalfW  = 64;
  localparam int V4W    = 32;
  localparam int PrefW  = 8;

  localparam logic [PrefW-1:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [PrefW-1:0] V6_MAX_PREFIX = 8'd128;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PREFIX   = 2'd1,
    ST_HOSTBITS = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic              family;
    logic [PrefW-1:0]  prefix;
    logic [AddrW-1:0]  addr;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Leading-ones mask over the 128-bit key; IPv4 keys live in bits 31..0.
  function automatic logic [AddrW-1:0] prefix_mask(input logic [PrefW-1:0] plen,
                                                   input logic             v6);
    logic [AddrW-1:0] m;
    for (int b = 0; b < AddrW; b++) begin
      if (v6) begin
        m[b] = (PrefW'(AddrW - 1 - b) < plen);
      end else if (b < V4W) begin
        m[b] = (PrefW'(V4W - 1 - b) < plen);
      end else begin
        m[b] = 1'b0;
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/sam_ram.sv =====
// ----------------------------------------------------------------------------
// sam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sam_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/subnet_acl_match.sv =====
// ----------------------------------------------------------------------------
// subnet_acl_match
// IPv4/IPv6 subnet table: insert checked entries, look up host addresses.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | word
// in      | sink      | in_valid_i/in_ready_o  | func, is_v6, addr_hi, addr_lo, prefix_len
// out     | source    | out_valid_o/out_ready_i| status, allowed
//
// Insert: the entry is checked and written to the table in S_INSERT, which also registers the result.
// Lookup: every stored entry is read and compared; the table RAM read port
//   delivers one entry per cycle to the single mask-and-compare unit.
// Reset empties the table at once through the entry count; no clearing pass.
// A result waiting on out_ready_i holds the next item's completion.
// ----------------------------------------------------------------------------
module subnet_acl_match (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic                       is_v6_i,
  input  logic [sam_pkg::HalfW-1:0]  addr_hi_i,
  input  logic [sam_pkg::HalfW-1:0]  addr_lo_i,
  input  logic [sam_pkg::PrefW-1:0]  prefix_len_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic                       allowed_o
);

  import sam_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_INSERT = 3'b010,
    S_SCAN   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic              allowed_q, allowed_d;

  logic              v6_q;
  logic [AddrW-1:0]  key_q;
  logic [PrefW-1:0]  prefix_q;

  logic              accept;
  logic              slot_free;
  logic              issue;
  logic              we;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [EntryW-1:0] rdata;
  logic [PrefW-1:0]  mask_len;
  logic [AddrW-1:0]  mask;
  logic              match;
  status_e           ins_status;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign issue     = (state_q == S_SCAN) && (idx_q < count_q);

  // shared mask unit: insert prefix or the prefix of the entry being compared
  assign rd_entry = entry_t'(rdata);
  assign mask_len = (state_q == S_INSERT) ? prefix_q : rd_entry.prefix;
  assign mask     = prefix_mask(mask_len, v6_q);
  assign match    = (rd_entry.family == v6_q) && ((key_q & mask) == rd_entry.addr);

  always_comb begin
    ins_status = ST_OK;
    if (v6_q ? (prefix_q > V6_MAX_PREFIX) : (prefix_q > V4_MAX_PREFIX)) begin
      ins_status = ST_PREFIX;
    end else if (!v6_q && ((key_q & ~mask) != '0)) begin
      ins_status = ST_HOSTBITS;
    end else if (count_q >= CntW'(TABLE_ENTRIES)) begin
      ins_status = ST_FULL;
    end
  end

  assign we       = (state_q == S_INSERT) && slot_free && (ins_status == ST_OK);
  assign wr_entry = '{family: v6_q, prefix: prefix_q, addr: key_q & mask};

  sam_ram #(
    .Width (EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    allowed_d   = allowed_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = (func_i == FUNC_LOOKUP) ? S_SCAN : S_INSERT;
        end
      end
      S_INSERT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          status_d    = ins_status;
          allowed_d   = 1'b0;
          if (we) begin
            count_d = count_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        pend_d = issue;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q && match) begin
          hit_d = 1'b1;
        end
        if (!issue && !pend_q && slot_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          allowed_d   = hit_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      allowed_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      allowed_q   <= allowed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v6_q     <= is_v6_i;
      key_q    <= is_v6_i ? {addr_hi_i, addr_lo_i}
                          : {{(AddrW - V4W){1'b0}}, addr_lo_i[V4W-1:0]};
      prefix_q <= prefix_len_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign allowed_o   = allowed_q;

endmodule

// ===== hdl/sam_checker.sv =====
// ----------------------------------------------------------------------------
// sam_checker
// Port-level assertions for subnet_acl_match, bound to the top level.
// ----------------------------------------------------------------------------
`include "subnet_acl_match_defines.svh"

module sam_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic                       allowed_o
);

  import sam_pkg::*;

  `SAM_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(allowed_o),
    "result word changed while stalled")

  `SAM_ASSERT(a_busy_after_accept,
    in_valid_i && in_ready_o |=> !in_ready_o,
    "block ready again right after taking a word")

  `SAM_ASSERT_NEVER(a_allowed_status,
    out_valid_o && allowed_o && (status_o != ST_OK),
    "allowed set with a reject status")

  `SAM_ASSERT(a_result_after_work,
    $rose(out_valid_o) |-> !$past(in_ready_o),
    "result appeared without an item in progress")

endmodule

bind subnet_acl_match sam_checker u_sam_checker (.*);
